>>> rtl/gscc_pkg.sv
// Shared types and constants of the greedy subsequence cover count unit.
package gscc_pkg;

   // Default store depth and pass counter width
   localparam int SRC_DEPTH_DEF  = 64;
   localparam int PASS_WIDTH_DEF = 16;

   // Fixed field widths of the item ports
   localparam int SYMBOL_W = 8;
   localparam int PASSES_W = 16;

   // Item kinds carried in req_type
   localparam logic KIND_SOURCE = 1'b0;
   localparam logic KIND_TARGET = 1'b1;

   // One input item
   typedef struct packed {
      logic                req_type;
      logic [SYMBOL_W-1:0] symbol;
      logic                last;
   } gscc_req_type;

   // One result item
   typedef struct packed {
      logic [PASSES_W-1:0] passes;
      logic                impossible;
   } gscc_rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic src_store;
      logic tgt_begin;
      logic scan_en;
      logic finish;
   } gscc_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic failed;
      logic scan_done;
   } gscc_status_type;

endpackage

>>> rtl/gscc_ctrl.sv
// Controller state machine: accepts items and sequences the source scan.
module gscc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      req_kind,
   input  gscc_pkg::gscc_status_type status,
   output logic                      busy,
   output gscc_pkg::gscc_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && (state_ff == ST_IDLE);

   // Commands
   always_comb begin
      cmd.src_store = accept && (req_kind == gscc_pkg::KIND_SOURCE);
      cmd.tgt_begin = accept && (req_kind == gscc_pkg::KIND_TARGET);
      cmd.scan_en   = (state_ff == ST_SCAN);
      cmd.finish    = (state_ff == ST_FINISH);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd.tgt_begin) begin
               // a failed query skips the scan
               state_in = status.failed ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/gscc_datapath.sv
// Datapath: source store, scan pointer, compare pipeline and query counters.
module gscc_datapath #(
   parameter int SRC_DEPTH  = gscc_pkg::SRC_DEPTH_DEF,
   parameter int PASS_WIDTH = gscc_pkg::PASS_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  gscc_pkg::gscc_req_type    req_item,
   input  gscc_pkg::gscc_cmd_type    cmd,
   output gscc_pkg::gscc_status_type status,
   output logic                      rsp_valid,
   output gscc_pkg::gscc_rsp_type    rsp_item
);

   localparam int LEN_W = $clog2(SRC_DEPTH + 1);
   localparam int IDX_W = (SRC_DEPTH > 1) ? $clog2(SRC_DEPTH) : 1;

   // Source store
   logic [gscc_pkg::SYMBOL_W-1:0] mem [SRC_DEPTH];

   logic [LEN_W-1:0]              length_ff, length_in;
   logic                          closed_ff, closed_in;
   logic [LEN_W-1:0]              scan_pos_ff, scan_pos_in;
   logic [PASS_WIDTH-1:0]         pass_ff, pass_in;
   logic                          failed_ff, failed_in;
   logic [LEN_W-1:0]              ptr_ff, ptr_in;
   logic                          cmp_valid_ff, cmp_valid_in;
   logic [LEN_W-1:0]              cmp_idx_ff;
   logic                          wrapped_ff, wrapped_in;
   logic [gscc_pkg::SYMBOL_W-1:0] rd_data_ff;
   logic [gscc_pkg::SYMBOL_W-1:0] sym_ff;
   logic                          last_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   gscc_pkg::gscc_rsp_type        rsp_item_ff, rsp_item_in;

   logic [LEN_W-1:0] eff_len;
   logic             store_ok;
   logic             issue_ok;
   logic             sweep_end;
   logic             hit;
   logic             miss;
   logic             wrap;

   // A source item while the load is closed begins a fresh source
   assign eff_len  = closed_ff ? '0 : length_ff;
   assign store_ok = (eff_len < LEN_W'(SRC_DEPTH));

   // Scan: issue one read a cycle, compare the previous read
   assign issue_ok  = (ptr_ff < length_ff);
   assign sweep_end = !cmp_valid_ff && !issue_ok;
   assign hit       = cmd.scan_en && cmp_valid_ff && (rd_data_ff == sym_ff);
   assign miss      = cmd.scan_en && sweep_end && wrapped_ff;
   assign wrap      = cmd.scan_en && sweep_end && !wrapped_ff;

   assign status.failed    = failed_ff;
   assign status.scan_done = hit || miss;

   // Store write and registered read
   always_ff @(posedge clock) begin
      if (cmd.src_store && store_ok) begin
         mem[eff_len[IDX_W-1:0]] <= req_item.symbol;
      end
      if (cmd.scan_en && issue_ok) begin
         rd_data_ff <= mem[ptr_ff[IDX_W-1:0]];
      end
   end

   // Next values of load, query and scan state
   always_comb begin
      length_in    = length_ff;
      closed_in    = closed_ff;
      scan_pos_in  = scan_pos_ff;
      pass_in      = pass_ff;
      failed_in    = failed_ff;
      ptr_in       = ptr_ff;
      cmp_valid_in = 1'b0;
      wrapped_in   = wrapped_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in  = rsp_item_ff;

      if (cmd.src_store) begin
         if (closed_ff) begin
            scan_pos_in = '0;
            pass_in     = PASS_WIDTH'(1);
            failed_in   = 1'b0;
         end
         length_in = store_ok ? eff_len + LEN_W'(1) : eff_len;
         closed_in = req_item.last;
      end

      if (cmd.tgt_begin) begin
         closed_in  = 1'b1;
         ptr_in     = scan_pos_ff;
         wrapped_in = 1'b0;
      end

      if (cmd.scan_en) begin
         if (hit) begin
            scan_pos_in = cmp_idx_ff + LEN_W'(1);
            if (wrapped_ff && (pass_ff != '1)) begin
               pass_in = pass_ff + PASS_WIDTH'(1);
            end
         end else if (miss) begin
            failed_in = 1'b1;
         end else if (wrap) begin
            ptr_in     = '0;
            wrapped_in = 1'b1;
         end else if (issue_ok) begin
            ptr_in       = ptr_ff + LEN_W'(1);
            cmp_valid_in = 1'b1;
         end
      end

      // Final target byte: emit and restart the query
      if (cmd.finish && last_ff) begin
         rsp_valid_in           = 1'b1;
         rsp_item_in.passes     = failed_ff ? '0 : gscc_pkg::PASSES_W'(pass_ff);
         rsp_item_in.impossible = failed_ff;
         scan_pos_in            = '0;
         pass_in                = PASS_WIDTH'(1);
         failed_in              = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff    <= '0;
         closed_ff    <= 1'b1;
         scan_pos_ff  <= '0;
         pass_ff      <= PASS_WIDTH'(1);
         failed_ff    <= 1'b0;
         cmp_valid_ff <= 1'b0;
         wrapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         length_ff    <= length_in;
         closed_ff    <= closed_in;
         scan_pos_ff  <= scan_pos_in;
         pass_ff      <= pass_in;
         failed_ff    <= failed_in;
         cmp_valid_ff <= cmp_valid_in;
         wrapped_ff   <= wrapped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      cmp_idx_ff  <= ptr_ff;
      rsp_item_ff <= rsp_item_in;
      if (cmd.tgt_begin) begin
         sym_ff  <= req_item.symbol;
         last_ff <= req_item.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

>>> rtl/greedy_subsequence_cover_count_unit.sv
// A source item leaves busy low, so sources stream one per cycle between target items.
// A target item holds busy while the store is read on the single read port, at most
// over the rest of the source and one wrapped sweep, through compare and sweep-end
// steps and a finish step; a failed query skips the scan.
// The result strobe is high in the first cycle with busy low after a final target byte.
// Reset (synchronous): source empty, load closed, query at its start values.
module greedy_subsequence_cover_count_unit #(
   parameter int SRC_DEPTH  = gscc_pkg::SRC_DEPTH_DEF,
   parameter int PASS_WIDTH = gscc_pkg::PASS_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  gscc_pkg::gscc_req_type req_item,
   output logic                   rsp_valid,
   output gscc_pkg::gscc_rsp_type rsp_item
);

   gscc_pkg::gscc_cmd_type    cmd;
   gscc_pkg::gscc_status_type status;

   // Sequencer
   gscc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_item.req_type),
      .status   (status),
      .busy     (busy),
      .cmd      (cmd)
   );

   // Store, scan and counters
   gscc_datapath #(
      .SRC_DEPTH  (SRC_DEPTH),
      .PASS_WIDTH (PASS_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

>>> rtl/gscc_checker.sv
// Port-level checks of the unit, bound to the top level.
module gscc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input gscc_pkg::gscc_req_type req_item,
   input logic                   rsp_valid,
   input gscc_pkg::gscc_rsp_type rsp_item
);

   // A target item always occupies the unit
   a_target_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.req_type == gscc_pkg::KIND_TARGET)) |=> busy)
      else $error("target item did not raise busy");

   // A source item does not raise busy
   a_source_quick: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.req_type == gscc_pkg::KIND_SOURCE)) |=> !busy)
      else $error("source item raised busy");

   // Results come only as the unit turns idle, never back to back
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result outside the end of a target item");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two results in consecutive cycles");

   // An impossible query reports zero passes
   a_impossible_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.impossible) |-> (rsp_item.passes == '0))
      else $error("impossible result with nonzero passes");

endmodule

bind greedy_subsequence_cover_count_unit gscc_checker u_gscc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
